// ===== rtl/core/drn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package drn_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_W       = 5;

   localparam int NW          = 48;  // signed width of a vector entering normalization
   localparam int XW          = 31;  // component magnitude after alignment
   localparam int SQRT_STEPS  = 32;
   localparam int QW          = 15;  // quotient bits
   localparam int SHIFT_CELLS = 6;

   localparam logic signed [32:0] Q28_PI      = 33'sd843314857;
   localparam logic signed [32:0] Q28_TWO_PI  = 33'sd1686629713;
   localparam logic signed [32:0] Q28_HALF_PI = 33'sd421657428;
   localparam logic signed [31:0] Q28_GAIN    = 32'sd163008219;

   typedef logic signed [NW-1:0] wide_type;
   typedef logic signed [15:0]   unit_type;
   typedef logic signed [31:0]   word_type;

   typedef struct packed {
      word_type [2:0] cosv;
      word_type [2:0] sinv;
      logic     [2:0] skip;
      unit_type [2:0] keep;
      logic           zlen;
   } side_type;

   typedef struct packed {
      word_type [2:0] x;
      word_type [2:0] y;
      word_type [2:0] z;
      logic     [2:0] flip;
      logic     [2:0] skip;
      word_type [2:0] vec;
   } cordic_type;

   typedef struct packed {
      logic [63:0]          sq;
      logic [34:0]          rem;
      logic [31:0]          root;
      logic [2:0][XW-1:0]   xm;
      logic [2:0]           neg;
      logic                 zero;
      side_type             side;
   } sqrt_type;

   typedef struct packed {
      logic [2:0][31:0]     rem;
      logic [2:0][QW-1:0]   low;
      logic [2:0][QW-1:0]   quo;
      logic [31:0]          mag;
      logic [2:0]           neg;
      logic                 zero;
      side_type             side;
   } div_type;

   // atan(2^-i) in Q.28
   function automatic word_type atan_q28(input logic [STEP_W-1:0] idx);
      word_type r;
      case (idx)
         5'd0:  r = 32'sd210828714;
         5'd1:  r = 32'sd124459457;
         5'd2:  r = 32'sd65760959;
         5'd3:  r = 32'sd33381290;
         5'd4:  r = 32'sd16755422;
         5'd5:  r = 32'sd8385879;
         5'd6:  r = 32'sd4193963;
         5'd7:  r = 32'sd2097109;
         5'd8:  r = 32'sd1048571;
         5'd9:  r = 32'sd524287;
         5'd10: r = 32'sd262144;
         5'd11: r = 32'sd131072;
         5'd12: r = 32'sd65536;
         5'd13: r = 32'sd32768;
         5'd14: r = 32'sd16384;
         5'd15: r = 32'sd8192;
         5'd16: r = 32'sd4096;
         5'd17: r = 32'sd2048;
         5'd18: r = 32'sd1024;
         5'd19: r = 32'sd512;
         5'd20: r = 32'sd256;
         5'd21: r = 32'sd128;
         5'd22: r = 32'sd64;
         5'd23: r = 32'sd32;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/drn_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface drn_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] vec_x;
   logic signed [31:0] vec_y;
   logic signed [31:0] vec_z;
   logic signed [15:0] angle_about_x;
   logic signed [15:0] angle_about_y;
   logic signed [15:0] angle_about_z;

   modport source (output valid, vec_x, vec_y, vec_z, angle_about_x, angle_about_y,
                   angle_about_z, input ready);
   modport sink (input valid, vec_x, vec_y, vec_z, angle_about_x, angle_about_y,
                 angle_about_z, output ready);
endinterface

interface drn_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] unit_x;
   logic signed [15:0] unit_y;
   logic signed [15:0] unit_z;
   logic               zero_length;

   modport source (output valid, unit_x, unit_y, unit_z, zero_length, input ready);
   modport sink (input valid, unit_x, unit_y, unit_z, zero_length, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/drn_cordic_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drn_cordic_cell import drn_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic [STEP_W-1:0] step,
   input  logic              in_valid,
   input  cordic_type        in_data,
   output logic              out_valid,
   output cordic_type        out_data
);
   logic       valid_ff;
   cordic_type data_ff;
   cordic_type data_in;
   word_type   ang;

   always_comb begin
      data_in = in_data;
      ang = atan_q28(step);
      for (int i = 0; i < 3; i++) begin
         if (!in_data.z[i][31]) begin
            data_in.x[i] = in_data.x[i] - ($signed(in_data.y[i]) >>> step);
            data_in.y[i] = in_data.y[i] + ($signed(in_data.x[i]) >>> step);
            data_in.z[i] = in_data.z[i] - ang;
         end else begin
            data_in.x[i] = in_data.x[i] + ($signed(in_data.y[i]) >>> step);
            data_in.y[i] = in_data.y[i] - ($signed(in_data.x[i]) >>> step);
            data_in.z[i] = in_data.z[i] + ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/drn_sqrt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drn_sqrt_cell import drn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  sqrt_type in_data,
   output logic     out_valid,
   output sqrt_type out_data
);
   logic        valid_ff;
   sqrt_type    data_ff;
   sqrt_type    data_in;
   logic [34:0] rem2;
   logic [34:0] trial;

   // one root bit per cell
   always_comb begin
      data_in = in_data;
      rem2 = {in_data.rem[32:0], in_data.sq[63:62]};
      trial = {1'b0, in_data.root, 2'b01};
      data_in.sq = in_data.sq << 2;
      if (rem2 >= trial) begin
         data_in.rem  = rem2 - trial;
         data_in.root = {in_data.root[30:0], 1'b1};
      end else begin
         data_in.rem  = rem2;
         data_in.root = {in_data.root[30:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/drn_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drn_div_cell import drn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    adv,
   input  logic    in_valid,
   input  div_type in_data,
   output logic    out_valid,
   output div_type out_data
);
   logic        valid_ff;
   div_type     data_ff;
   div_type     data_in;
   logic [32:0] rem2;
   logic [32:0] mag33;

   // one quotient bit per cell for each component
   always_comb begin
      data_in = in_data;
      mag33 = {1'b0, in_data.mag};
      rem2 = '0;
      for (int i = 0; i < 3; i++) begin
         rem2 = {in_data.rem[i], in_data.low[i][QW-1]};
         data_in.low[i] = in_data.low[i] << 1;
         if (rem2 >= mag33) begin
            data_in.rem[i] = 32'(rem2 - mag33);
            data_in.quo[i] = {in_data.quo[i][QW-2:0], 1'b1};
         end else begin
            data_in.rem[i] = rem2[31:0];
            data_in.quo[i] = {in_data.quo[i][QW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule
`default_nettype wire

// ===== rtl/core/drn_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
module drn_norm import drn_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           adv,
   input  logic           in_valid,
   input  wide_type [2:0] in_vec,
   input  side_type       in_side,
   output logic           out_valid,
   output unit_type [2:0] out_unit,
   output logic           out_zero,
   output side_type       out_side
);
   typedef struct packed {
      logic [2:0][NW-1:0] u;
      logic [NW-1:0]      m;
      logic [2:0]         neg;
      logic               zero;
      side_type           side;
   } shift_type;

   typedef struct packed {
      logic [2:0][XW-1:0]   xm;
      logic [2:0][2*XW-1:0] sq;
      logic [2:0]           neg;
      logic                 zero;
      side_type             side;
   } square_type;

   // magnitude stage
   logic               abs_valid_ff;
   logic [2:0][NW-1:0] abs_u_ff;
   logic [2:0]         abs_neg_ff;
   side_type           abs_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         abs_valid_ff <= 1'b0;
      end else if (adv) begin
         abs_valid_ff <= in_valid;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            abs_u_ff[i]   <= in_vec[i][NW-1] ? -in_vec[i] : in_vec[i];
            abs_neg_ff[i] <= in_vec[i][NW-1];
         end
         abs_side_ff <= in_side;
      end
   end

   // largest magnitude, then align it to the top bit in six shift cells
   logic          sh_valid_ff [SHIFT_CELLS+1];
   shift_type     sh_ff [SHIFT_CELLS+1];
   logic [NW-1:0] m01;
   logic [NW-1:0] mx;

   always_comb begin
      m01 = (abs_u_ff[0] > abs_u_ff[1]) ? abs_u_ff[0] : abs_u_ff[1];
      mx  = (m01 > abs_u_ff[2]) ? m01 : abs_u_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sh_valid_ff[0] <= 1'b0;
      end else if (adv) begin
         sh_valid_ff[0] <= abs_valid_ff;
      end
      if (adv) begin
         sh_ff[0].u    <= abs_u_ff;
         sh_ff[0].m    <= mx;
         sh_ff[0].neg  <= abs_neg_ff;
         sh_ff[0].zero <= (mx == '0);
         sh_ff[0].side <= abs_side_ff;
      end
   end

   for (genvar k = 1; k <= SHIFT_CELLS; k++) begin : g_shift
      localparam int SH = 64 >> k;
      shift_type nxt;

      always_comb begin
         nxt = sh_ff[k-1];
         if (sh_ff[k-1].m[NW-1 -: SH] == '0) begin
            nxt.m = sh_ff[k-1].m << SH;
            for (int i = 0; i < 3; i++) begin
               nxt.u[i] = sh_ff[k-1].u[i] << SH;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sh_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            sh_valid_ff[k] <= sh_valid_ff[k-1];
         end
         if (adv) begin
            sh_ff[k] <= nxt;
         end
      end
   end

   // squares, then their sum
   logic       sq_valid_ff;
   square_type sq_ff;
   logic       sum_valid_ff;
   sqrt_type   sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (adv) begin
         sq_valid_ff  <= sh_valid_ff[SHIFT_CELLS];
         sum_valid_ff <= sq_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff.xm[i] <= sh_ff[SHIFT_CELLS].u[i][NW-1 -: XW];
            sq_ff.sq[i] <= (2*XW)'(sh_ff[SHIFT_CELLS].u[i][NW-1 -: XW])
                           * (2*XW)'(sh_ff[SHIFT_CELLS].u[i][NW-1 -: XW]);
         end
         sq_ff.neg  <= sh_ff[SHIFT_CELLS].neg;
         sq_ff.zero <= sh_ff[SHIFT_CELLS].zero;
         sq_ff.side <= sh_ff[SHIFT_CELLS].side;

         sum_ff.sq   <= 64'(sq_ff.sq[0]) + 64'(sq_ff.sq[1]) + 64'(sq_ff.sq[2]);
         sum_ff.rem  <= '0;
         sum_ff.root <= '0;
         sum_ff.xm   <= sq_ff.xm;
         sum_ff.neg  <= sq_ff.neg;
         sum_ff.zero <= sq_ff.zero;
         sum_ff.side <= sq_ff.side;
      end
   end

   // square root chain
   logic     sr_valid [SQRT_STEPS+1];
   sqrt_type sr_data  [SQRT_STEPS+1];

   assign sr_valid[0] = sum_valid_ff;
   assign sr_data[0]  = sum_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      drn_sqrt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (sr_valid[k]),
         .in_data   (sr_data[k]),
         .out_valid (sr_valid[k+1]),
         .out_data  (sr_data[k+1])
      );
   end

   // division setup: numerator is x * 2^14 + mag / 2
   logic            dv_init_valid_ff;
   div_type         dv_init_ff;
   sqrt_type        sr_last;
   logic [2:0][45:0] num;

   assign sr_last = sr_data[SQRT_STEPS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = (46'(sr_last.xm[i]) << 14) + 46'(sr_last.root[31:1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_init_valid_ff <= 1'b0;
      end else if (adv) begin
         dv_init_valid_ff <= sr_valid[SQRT_STEPS];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dv_init_ff.rem[i] <= {1'b0, num[i][45:QW]};
            dv_init_ff.low[i] <= num[i][QW-1:0];
            dv_init_ff.quo[i] <= '0;
         end
         dv_init_ff.mag  <= sr_last.root;
         dv_init_ff.neg  <= sr_last.neg;
         dv_init_ff.zero <= sr_last.zero;
         dv_init_ff.side <= sr_last.side;
      end
   end

   logic    dv_valid [QW+1];
   div_type dv_data  [QW+1];

   assign dv_valid[0] = dv_init_valid_ff;
   assign dv_data[0]  = dv_init_ff;

   for (genvar k = 0; k < QW; k++) begin : g_div
      drn_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (dv_valid[k]),
         .in_data   (dv_data[k]),
         .out_valid (dv_valid[k+1]),
         .out_data  (dv_data[k+1])
      );
   end

   // apply signs; force zero for a zero vector
   logic           fin_valid_ff;
   unit_type [2:0] fin_unit_ff;
   logic           fin_zero_ff;
   side_type       fin_side_ff;
   div_type        dv_last;

   assign dv_last = dv_data[QW];

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (adv) begin
         fin_valid_ff <= dv_valid[QW];
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_last.zero) begin
               fin_unit_ff[i] <= '0;
            end else if (dv_last.neg[i]) begin
               fin_unit_ff[i] <= -{1'b0, dv_last.quo[i]};
            end else begin
               fin_unit_ff[i] <= {1'b0, dv_last.quo[i]};
            end
         end
         fin_zero_ff <= dv_last.zero;
         fin_side_ff <= dv_last.side;
      end
   end

   assign out_valid = fin_valid_ff;
   assign out_unit  = fin_unit_ff;
   assign out_zero  = fin_zero_ff;
   assign out_side  = fin_side_ff;
endmodule
`default_nettype wire

// ===== rtl/core/direction_rotate_normalize_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Unit direction vector after a y, x, z Euler rotation.
// req_chan carries a Q16.16 vector and three Q3.12 angles; rsp_chan returns
// the rotated unit vector in Q1.14 with a flag for a zero-length input.
// Every transfer on req_chan yields exactly one transfer on rsp_chan, in order.
// Throughput: one item per cycle while the output buffer has room. The
// datapath is one long chain of cells (CORDIC steps, alignment shifts,
// square root bits, quotient bits) that all advance together, so a new
// item enters on every cycle unless both buffer entries are full. The four
// normalizations make up most of the path from request to response valid.
// Reset: synchronous, active high; clears every valid bit and the output
// buffer, no clearing pass. req_chan.ready is high in the first cycle after.
// Stall: a two-entry buffer sits in front of rsp_chan. The chain keeps
// running and keeps taking requests while one result waits; only with both
// entries full does the chain hold, and req_chan.ready drops with it.
module direction_rotate_normalize_core import drn_pkg::*; (
   input logic      clock,
   input logic      reset,
   drn_req_if.sink  req_chan,
   drn_rsp_if.source rsp_chan
);
   typedef struct packed {
      unit_type [2:0] unit;
      logic           zlen;
   } out_type;

   logic adv;
   logic [1:0] cnt_ff;

   // whole chain moves unless the output buffer is full
   assign adv = (cnt_ff != 2'd2);
   assign req_chan.ready = adv;

   // capture the request
   logic               in_valid_ff;
   word_type [2:0]     in_vec_ff;
   logic [2:0][15:0]   in_ang_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (adv) begin
         in_valid_ff <= req_chan.valid;
      end
      if (adv) begin
         in_vec_ff[0] <= req_chan.vec_x;
         in_vec_ff[1] <= req_chan.vec_y;
         in_vec_ff[2] <= req_chan.vec_z;
         in_ang_ff[0] <= req_chan.angle_about_x;
         in_ang_ff[1] <= req_chan.angle_about_y;
         in_ang_ff[2] <= req_chan.angle_about_z;
      end
   end

   // widen angles to Q.28 and wrap into [-pi, pi]
   logic                    wr_valid_ff;
   logic [2:0][31:0]        wr_z_ff;
   logic [2:0]              wr_skip_ff;
   word_type [2:0]          wr_vec_ff;
   logic signed [2:0][32:0] zw;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         zw[i] = {in_ang_ff[i][15], in_ang_ff[i], 16'b0};
         if ($signed(zw[i]) > Q28_PI) begin
            zw[i] = $signed(zw[i]) - Q28_TWO_PI;
         end else if ($signed(zw[i]) < -Q28_PI) begin
            zw[i] = $signed(zw[i]) + Q28_TWO_PI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_valid_ff <= 1'b0;
      end else if (adv) begin
         wr_valid_ff <= in_valid_ff;
      end
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            wr_z_ff[i]    <= zw[i][31:0];
            wr_skip_ff[i] <= (in_ang_ff[i] == '0);
         end
         wr_vec_ff <= in_vec_ff;
      end
   end

   // fold into [-pi/2, pi/2] and remember to flip cosine and sine
   logic                    fd_valid_ff;
   cordic_type              fd_ff;
   cordic_type              fd_in;
   logic signed [2:0][32:0] zf;

   always_comb begin
      fd_in.vec  = wr_vec_ff;
      fd_in.skip = wr_skip_ff;
      for (int i = 0; i < 3; i++) begin
         zf[i] = {wr_z_ff[i][31], wr_z_ff[i]};
         fd_in.flip[i] = 1'b0;
         if ($signed(zf[i]) > Q28_HALF_PI) begin
            zf[i] = $signed(zf[i]) - Q28_PI;
            fd_in.flip[i] = 1'b1;
         end else if ($signed(zf[i]) < -Q28_HALF_PI) begin
            zf[i] = $signed(zf[i]) + Q28_PI;
            fd_in.flip[i] = 1'b1;
         end
         fd_in.x[i] = Q28_GAIN;
         fd_in.y[i] = '0;
         fd_in.z[i] = zf[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fd_valid_ff <= 1'b0;
      end else if (adv) begin
         fd_valid_ff <= wr_valid_ff;
      end
      if (adv) begin
         fd_ff <= fd_in;
      end
   end

   // CORDIC chain, all three angles side by side
   logic       cv [CORDIC_RUN+1];
   cordic_type cd [CORDIC_RUN+1];

   assign cv[0] = fd_valid_ff;
   assign cd[0] = fd_ff;

   for (genvar k = 0; k < CORDIC_RUN; k++) begin : g_cordic
      drn_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .step      (STEP_W'(k)),
         .in_valid  (cv[k]),
         .in_data   (cd[k]),
         .out_valid (cv[k+1]),
         .out_data  (cd[k+1])
      );
   end

   // four normalizers: input vector, then after each rotation
   logic           nv_in    [4];
   wide_type [2:0] nvec_in  [4];
   side_type       nside_in [4];
   logic           nv_out   [4];
   unit_type [2:0] nunit_out[4];
   logic           nzero_out[4];
   side_type       nside_out[4];

   cordic_type cd_last;
   assign cd_last = cd[CORDIC_RUN];

   always_comb begin
      nv_in[0] = cv[CORDIC_RUN];
      nside_in[0].skip = cd_last.skip;
      nside_in[0].keep = '0;
      nside_in[0].zlen = 1'b0;
      for (int i = 0; i < 3; i++) begin
         nvec_in[0][i] = {{(NW-32){cd_last.vec[i][31]}}, cd_last.vec[i]};
         nside_in[0].cosv[i] = cd_last.flip[i] ? -cd_last.x[i] : cd_last.x[i];
         nside_in[0].sinv[i] = cd_last.flip[i] ? -cd_last.y[i] : cd_last.y[i];
      end
   end

   for (genvar n = 0; n < 4; n++) begin : g_norm
      drn_norm u_norm (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (nv_in[n]),
         .in_vec    (nvec_in[n]),
         .in_side   (nside_in[n]),
         .out_valid (nv_out[n]),
         .out_unit  (nunit_out[n]),
         .out_zero  (nzero_out[n]),
         .out_side  (nside_out[n])
      );
   end

   // rotations in order y, x, z; each rotates the pair (PI_A, PJ_A) and
   // leaves the angle's own axis alone. A zero angle keeps the vector as is.
   for (genvar r = 0; r < 3; r++) begin : g_rot
      localparam int AI   = (r == 0) ? 1 : ((r == 1) ? 0 : 2);
      localparam int PI_A = (r == 1) ? 1 : 0;
      localparam int PJ_A = (r == 2) ? 1 : 2;
      localparam int PREV = (r == 1) ? 1 : 0;

      unit_type [2:0]    a_cur;
      side_type          side_cur;
      word_type          cs;
      word_type          sn;
      logic              p_valid_ff;
      logic signed [47:0] pic_ff, pis_ff, pjc_ff, pjs_ff;
      unit_type          ak_ff;
      side_type          p_side_ff;
      logic              w_valid_ff;
      wide_type [2:0]    w_ff;
      side_type          w_side_ff;

      always_comb begin
         side_cur = nside_out[r];
         if (r == 0) begin
            a_cur = nunit_out[r];
            side_cur.zlen = nzero_out[r];
         end else if (nside_out[r].skip[PREV]) begin
            a_cur = nside_out[r].keep;
         end else begin
            a_cur = nunit_out[r];
         end
         side_cur.keep = a_cur;
         cs = nside_out[r].cosv[AI];
         // y rotation runs the other way round its pair
         sn = (r == 0) ? -nside_out[r].sinv[AI] : nside_out[r].sinv[AI];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            p_valid_ff <= 1'b0;
            w_valid_ff <= 1'b0;
         end else if (adv) begin
            p_valid_ff <= nv_out[r];
            w_valid_ff <= p_valid_ff;
         end
         if (adv) begin
            pic_ff    <= 48'(a_cur[PI_A]) * 48'(cs);
            pis_ff    <= 48'(a_cur[PI_A]) * 48'(sn);
            pjc_ff    <= 48'(a_cur[PJ_A]) * 48'(cs);
            pjs_ff    <= 48'(a_cur[PJ_A]) * 48'(sn);
            ak_ff     <= a_cur[AI];
            p_side_ff <= side_cur;

            w_ff[PI_A] <= pic_ff - pjs_ff;
            w_ff[PJ_A] <= pis_ff + pjc_ff;
            w_ff[AI]   <= {{(NW-44){ak_ff[15]}}, ak_ff, 28'b0};
            w_side_ff  <= p_side_ff;
         end
      end

      assign nv_in[r+1]    = w_valid_ff;
      assign nvec_in[r+1]  = w_ff;
      assign nside_in[r+1] = w_side_ff;
   end

   // final pick, then a two-entry buffer toward the receiver
   logic    fin_valid;
   out_type fin;

   always_comb begin
      fin_valid = nv_out[3];
      fin.zlen  = nside_out[3].zlen;
      fin.unit  = nside_out[3].skip[2] ? nside_out[3].keep : nunit_out[3];
   end

   out_type buf_ff [2];
   logic    wr_ptr_ff;
   logic    rd_ptr_ff;
   logic    push;
   logic    pop;

   assign push = fin_valid && adv;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
      if (push) begin
         buf_ff[wr_ptr_ff] <= fin;
      end
   end

   assign rsp_chan.valid       = (cnt_ff != 2'd0);
   assign rsp_chan.unit_x      = buf_ff[rd_ptr_ff].unit[0];
   assign rsp_chan.unit_y      = buf_ff[rd_ptr_ff].unit[1];
   assign rsp_chan.unit_z      = buf_ff[rd_ptr_ff].unit[2];
   assign rsp_chan.zero_length = buf_ff[rd_ptr_ff].zlen;

   a_zero_gives_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_length |->
         rsp_chan.unit_x == '0 && rsp_chan.unit_y == '0 && rsp_chan.unit_z == '0)
      else $error("zero-length result with nonzero components");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |->
         rsp_chan.unit_x >= -16'sd16384 && rsp_chan.unit_x <= 16'sd16384 &&
         rsp_chan.unit_y >= -16'sd16384 && rsp_chan.unit_y <= 16'sd16384 &&
         rsp_chan.unit_z >= -16'sd16384 && rsp_chan.unit_z <= 16'sd16384)
      else $error("unit component out of range");

   a_buf_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !pop |=> cnt_ff == 2'd2)
      else $error("output buffer lost an entry");
endmodule
`default_nettype wire
